### design/quoted_token_splitter_core_defines.svh
// ----------------------------------------------------------------------------
// Quoted token splitter assertion macros
// Shared concurrent assertion forms; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_SPLITTER_CORE_DEFINES_SVH
`define QUOTED_TOKEN_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qts assertion failed");

// Next-cycle implication, checked outside reset.
`define QTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qts assertion failed");

`endif

### design/qts_pkg.sv
// ----------------------------------------------------------------------------
// Quoted token splitter package
// Character codes, state and result types, and the small decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package qts_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_V  = 8'h76;
  localparam logic [7:0] CH_LOW_X  = 8'h78;

  // Decoded values of the named escapes
  localparam logic [7:0] VAL_BEL = 8'd7;
  localparam logic [7:0] VAL_BS  = 8'd8;
  localparam logic [7:0] VAL_HT  = 8'd9;
  localparam logic [7:0] VAL_NL  = 8'd10;
  localparam logic [7:0] VAL_VT  = 8'd11;
  localparam logic [7:0] VAL_FF  = 8'd12;
  localparam logic [7:0] VAL_CR  = 8'd13;
  localparam logic [7:0] VAL_ESC = 8'd27;

  localparam logic [1:0] HEX_DIGITS = 2'd2;
  localparam logic [1:0] OCT_DIGITS = 2'd3;

  typedef enum logic [1:0] {
    Q_NONE   = 2'd0,
    Q_SINGLE = 2'd1,
    Q_DOUBLE = 2'd2
  } quote_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_SLASH = 2'd1,
    ESC_HEX   = 2'd2,
    ESC_OCT   = 2'd3
  } esc_phase_t;

  typedef struct packed {
    logic       in_token;
    quote_t     quote_kind;
    esc_phase_t escape_phase;
    logic [1:0] digit_count;
    logic [7:0] escape_value;
  } qts_state_t;

  localparam qts_state_t STATE_RESET = '{
    in_token:     1'b0,
    quote_kind:   Q_NONE,
    escape_phase: ESC_NONE,
    digit_count:  2'd0,
    escape_value: 8'd0
  };

  // Up to two result bytes caused by one character; byte0 leaves first
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } qts_result_t;

  // {valid, value} of a hex digit in either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_LOW_A && c <= CH_LOW_F) begin
      d = c - CH_LOW_A + 8'd10;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_UP_A && c <= CH_UP_F) begin
      d = c - CH_UP_A + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  // {hit, value} for the single-letter escapes
  function automatic logic [8:0] named_escape(input logic [7:0] c);
    case (c) inside
      CH_LOW_A:          return {1'b1, VAL_BEL};
      CH_LOW_B:          return {1'b1, VAL_BS};
      CH_LOW_E, CH_UP_E: return {1'b1, VAL_ESC};
      CH_LOW_F:          return {1'b1, VAL_FF};
      CH_LOW_N:          return {1'b1, VAL_NL};
      CH_LOW_R:          return {1'b1, VAL_CR};
      CH_LOW_T:          return {1'b1, VAL_HT};
      CH_LOW_V:          return {1'b1, VAL_VT};
      default:           return 9'd0;
    endcase
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

endpackage

`default_nettype wire

### design/qts_char_if.sv
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel carrying one input character per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qts_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

### design/qts_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one token byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface qts_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### design/qts_decode.sv
// ----------------------------------------------------------------------------
// Quoted token splitter decode
// Next state and result bytes for one character, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module qts_decode (
  input  wire logic [7:0]         c,
  input  wire qts_pkg::qts_state_t st,
  output qts_pkg::qts_state_t     st_next,
  output qts_pkg::qts_result_t    res
);
  import qts_pkg::*;

  logic [4:0]  hx;
  logic [8:0]  nm;
  logic        is_hex;
  logic        digit_ok;
  logic [1:0]  cnt_inc;
  logic [7:0]  val_acc;
  logic        run_plain;
  logic        fin_emit;
  logic [7:0]  fin_val;
  logic        pl_emit;
  logic [7:0]  pl_val;
  qts_state_t  s;
  quote_t      kind;

  always_comb begin
    hx       = hex_digit(c);
    nm       = named_escape(c);
    is_hex   = st.escape_phase == ESC_HEX;
    digit_ok = hx[4] && (is_hex || !hx[3]);
    cnt_inc  = st.digit_count + 2'd1;
    val_acc  = is_hex ? {st.escape_value[3:0], hx[3:0]}
                      : {st.escape_value[4:0], hx[2:0]};
    kind     = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;

    s         = st;
    run_plain = 1'b1;
    fin_emit  = 1'b0;
    fin_val   = st.escape_value;

    // Numeric escape in progress: take a digit or close it out
    if (st.escape_phase == ESC_HEX || st.escape_phase == ESC_OCT) begin
      if (digit_ok) begin
        run_plain = 1'b0;
        if (cnt_inc >= (is_hex ? HEX_DIGITS : OCT_DIGITS)) begin
          fin_emit       = val_acc != 8'd0;
          fin_val        = val_acc;
          s.escape_phase = ESC_NONE;
          s.digit_count  = 2'd0;
          s.escape_value = 8'd0;
        end else begin
          s.digit_count  = cnt_inc;
          s.escape_value = val_acc;
        end
      end else begin
        fin_emit       = st.escape_value != 8'd0;
        s.escape_phase = ESC_NONE;
        s.digit_count  = 2'd0;
        s.escape_value = 8'd0;
      end
    end

    pl_emit = 1'b0;
    pl_val  = c;
    st_next = s;
    if (run_plain) begin
      if (c == CH_NUL) begin
        pl_emit = s.in_token;
        pl_val  = CH_NUL;
        st_next = STATE_RESET;
      end else if (s.escape_phase == ESC_SLASH) begin
        st_next.escape_phase = ESC_NONE;
        if (nm[8]) begin
          pl_emit = 1'b1;
          pl_val  = nm[7:0];
        end else if (c == CH_LOW_X) begin
          st_next.escape_phase = ESC_HEX;
          st_next.digit_count  = 2'd0;
          st_next.escape_value = 8'd0;
        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
          st_next.escape_phase = ESC_OCT;
          st_next.digit_count  = 2'd1;
          st_next.escape_value = {5'd0, c[2:0]};
        end else begin
          pl_emit = 1'b1;
        end
      end else if (!s.in_token && is_space(c)) begin
        // skip leading whitespace
      end else begin
        st_next.in_token = 1'b1;
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
          if (s.quote_kind == Q_NONE) begin
            st_next.quote_kind = kind;
          end else if (s.quote_kind == kind) begin
            st_next.quote_kind = Q_NONE;
          end else begin
            pl_emit = 1'b1;
          end
        end else if (c == CH_BSLASH) begin
          st_next.escape_phase = ESC_SLASH;
        end else if ((c == CH_SPACE || c == CH_TAB) && s.quote_kind == Q_NONE) begin
          pl_emit          = 1'b1;
          pl_val           = CH_NUL;
          st_next.in_token = 1'b0;
        end else begin
          pl_emit = 1'b1;
        end
      end
    end

    // Pack: the finished escape value always goes out before the plain byte
    res.count = {1'b0, fin_emit} + {1'b0, pl_emit};
    res.byte0 = fin_emit ? fin_val : pl_val;
    res.byte1 = pl_val;
  end

endmodule

`default_nettype wire

### design/quoted_token_splitter_core.sv
// ----------------------------------------------------------------------------
// Quoted token splitter core
// Shell-style word splitter with quote grouping and C escape decoding.
// ----------------------------------------------------------------------------
// Takes one character per cycle on chars and emits decoded token bytes on
// tokens, a zero byte closing each token; last_of_run flags the final byte
// caused by a character. A character is registered, decoded against the
// tokenizer state and its bytes land in a two-entry result register, so a
// byte passes the input register and then the result register. The
// sustained rate is one character per cycle while each character yields at
// most one byte and the sink keeps ready high; a character that yields two
// bytes holds the single result port until both are taken, and the next
// character that yields bytes waits for that.
`default_nettype none

module quoted_token_splitter_core (
  input  wire logic clk,
  input  wire logic rst,
  qts_char_if.sink     chars,
  qts_result_if.source tokens
);
  import qts_pkg::*;
  `include "quoted_token_splitter_core_defines.svh"

  logic        in_v;
  logic [7:0]  in_char;
  qts_state_t  st;
  qts_state_t  st_next;
  qts_result_t res;

  logic [1:0]  cnt;
  logic [1:0]  cnt_next;
  logic [7:0]  b0;
  logic [7:0]  b0_next;
  logic [7:0]  b1;
  logic [7:0]  b1_next;

  logic        pop;
  logic        buf_free;
  logic        dec_fire;
  logic        load;

  qts_decode u_decode (
    .c       (in_char),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  assign pop      = tokens.valid && tokens.ready;
  assign buf_free = (cnt == 2'd0) || (cnt == 2'd1 && tokens.ready);
  assign dec_fire = in_v && (buf_free || res.count == 2'd0);
  assign load     = dec_fire && res.count != 2'd0;

  assign chars.ready        = !in_v || dec_fire;
  assign tokens.valid       = cnt != 2'd0;
  assign tokens.out_byte    = b0;
  assign tokens.last_of_run = cnt == 2'd1;

  always_comb begin
    cnt_next = cnt;
    b0_next  = b0;
    b1_next  = b1;
    if (load) begin
      cnt_next = res.count;
      b0_next  = res.byte0;
      b1_next  = res.byte1;
    end else if (pop) begin
      // advance the second byte to the head
      cnt_next = cnt - 2'd1;
      b0_next  = b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
      st   <= STATE_RESET;
      cnt  <= 2'd0;
    end else begin
      if (chars.ready) in_v <= chars.valid;
      if (dec_fire) st <= st_next;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready) in_char <= chars.char_in;
    b0 <= b0_next;
    b1 <= b1_next;
  end

  `QTS_ASSERT_NOW(a_cnt_range, 1'b1, cnt != 2'd3)
  `QTS_ASSERT_NEXT(a_pair_drains, cnt == 2'd2 && pop, cnt == 2'd1)
  `QTS_ASSERT_NOW(a_quote_in_token, st.quote_kind != Q_NONE, st.in_token)
  `QTS_ASSERT_NOW(a_escape_in_token, st.escape_phase != ESC_NONE, st.in_token)
  `QTS_ASSERT_NOW(a_idle_escape_clear,
                  st.escape_phase == ESC_NONE || st.escape_phase == ESC_SLASH,
                  st.digit_count == 2'd0 && st.escape_value == 8'd0)

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted token splitter testbench
// Streams directed and random character strings into the splitter, predicts
// the decoded token bytes with a local tokenizer model and checks every byte
// taken from the result channel, under three source/sink pacing phases.
// ----------------------------------------------------------------------------

module testbench;
  import qts_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 584;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } token_byte_t;

  class token_scoreboard;
    qts_state_t  st;
    logic [7:0]  run_bytes[$];
    token_byte_t expected_bytes[$];
    int          errors;
    int          bytes_checked;
    int          tokens_closed;

    function void reset_state();
      st = STATE_RESET;
      expected_bytes.delete();
      errors = 0;
      bytes_checked = 0;
      tokens_closed = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= CH_LOW_A && c <= CH_LOW_F) return int'(c - CH_LOW_A) + 10;
      if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
      return -1;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
             c == CH_FF || c == CH_CR;
    endfunction

    function void finish_numeric();
      if (st.escape_value != 8'd0) run_bytes.push_back(st.escape_value);
      st.escape_phase = ESC_NONE;
      st.digit_count  = 2'd0;
      st.escape_value = 8'd0;
    endfunction

    function void decode_escape(logic [7:0] c);
      st.escape_phase = ESC_NONE;
      case (c) inside
        CH_LOW_A:          run_bytes.push_back(VAL_BEL);
        CH_LOW_B:          run_bytes.push_back(VAL_BS);
        CH_LOW_E, CH_UP_E: run_bytes.push_back(VAL_ESC);
        CH_LOW_F:          run_bytes.push_back(VAL_FF);
        CH_LOW_N:          run_bytes.push_back(VAL_NL);
        CH_LOW_R:          run_bytes.push_back(VAL_CR);
        CH_LOW_T:          run_bytes.push_back(VAL_HT);
        CH_LOW_V:          run_bytes.push_back(VAL_VT);
        CH_LOW_X: begin
          st.escape_phase = ESC_HEX;
          st.digit_count  = 2'd0;
          st.escape_value = 8'd0;
        end
        default: begin
          if (c >= CH_ZERO && c <= CH_SEVEN) begin
            st.escape_phase = ESC_OCT;
            st.digit_count  = 2'd1;
            st.escape_value = c - CH_ZERO;
          end else begin
            run_bytes.push_back(c);
          end
        end
      endcase
    endfunction

    function void handle_plain(logic [7:0] c);
      quote_t kind;
      if (c == CH_NUL) begin
        if (st.in_token) run_bytes.push_back(CH_NUL);
        st = STATE_RESET;
        return;
      end
      if (st.escape_phase == ESC_SLASH) begin
        decode_escape(c);
        return;
      end
      if (!st.in_token) begin
        if (is_blank(c)) return;
        st.in_token = 1'b1;
      end
      if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        kind = (c == CH_SQUOTE) ? Q_SINGLE : Q_DOUBLE;
        // open, close, or keep a quote of the other kind as text
        if (st.quote_kind == Q_NONE) st.quote_kind = kind;
        else if (st.quote_kind == kind) st.quote_kind = Q_NONE;
        else run_bytes.push_back(c);
      end else if (c == CH_BSLASH) begin
        st.escape_phase = ESC_SLASH;
      end else if ((c == CH_SPACE || c == CH_TAB) && st.quote_kind == Q_NONE) begin
        run_bytes.push_back(CH_NUL);
        st.in_token = 1'b0;
      end else begin
        run_bytes.push_back(c);
      end
    endfunction

    // Advance the tokenizer by one accepted character and queue its bytes
    function void note_char(logic [7:0] c);
      int         dv;
      bit         hex;
      logic [1:0] full_count;
      token_byte_t tb_item;
      run_bytes.delete();
      if (st.escape_phase == ESC_HEX || st.escape_phase == ESC_OCT) begin
        dv  = digit_of(c);
        hex = (st.escape_phase == ESC_HEX);
        if (dv >= 0 && (hex || dv < 8)) begin
          st.escape_value = hex ? {st.escape_value[3:0], dv[3:0]}
                                : {st.escape_value[4:0], dv[2:0]};
          st.digit_count  = st.digit_count + 2'd1;
          full_count = hex ? HEX_DIGITS : OCT_DIGITS;
          if (st.digit_count >= full_count) finish_numeric();
        end else begin
          // a non-digit cuts the escape short and is then handled on its own
          finish_numeric();
          handle_plain(c);
        end
      end else begin
        handle_plain(c);
      end
      foreach (run_bytes[i]) begin
        tb_item.value = run_bytes[i];
        tb_item.last  = (i == run_bytes.size() - 1);
        expected_bytes.push_back(tb_item);
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [7:0] got_value, logic got_last);
      token_byte_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", got_value, got_last));
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (want.value == CH_NUL) tokens_closed++;
      if (got_value !== want.value || got_last !== want.last)
        report_mismatch($sformatf("got byte %02h last %0b, wanted byte %02h last %0b",
                                  got_value, got_last, want.value, want.last));
    endtask
  endclass

  logic clk;
  logic rst;

  qts_char_if   chars_if();
  qts_result_if tokens_if();

  quoted_token_splitter_core dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  token_scoreboard books;
  int sender_idle_pct;
  int sink_idle_pct;
  int n_sent;
  int n_strings;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(negedge clk) begin
    tokens_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && tokens_if.valid && tokens_if.ready)
      books.check_result(tokens_if.out_byte, tokens_if.last_of_run);
  end

  // Stop the run when neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid   <= 1'b1;
    chars_if.char_in <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    books.note_char(c);
    n_sent++;
    @(negedge clk);
  endtask

  // Hold the source off until every queued byte has come out
  task automatic drain_results();
    chars_if.valid <= 1'b0;
    do @(negedge clk); while (books.pending() != 0);
  endtask

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return CH_ZERO + v[7:0];
    if ($urandom_range(1)) return CH_LOW_A + v[7:0] - 8'd10;
    return CH_UP_A + v[7:0] - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0:       return CH_TAB;
      1:       return CH_LF;
      2:       return CH_VT;
      3:       return CH_FF;
      4:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic send_piece();
    int         n;
    int         v;
    logic [7:0] named [9];
    logic [7:0] lit [5];
    named = '{CH_LOW_A, CH_LOW_B, CH_LOW_E, CH_UP_E, CH_LOW_F,
              CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_V};
    lit   = '{CH_SPACE, CH_TAB, CH_SQUOTE, CH_DQUOTE, CH_BSLASH};
    case ($urandom_range(11)) inside
      [0:2]: begin
        v = $urandom_range(25);
        send_char(($urandom_range(1) ? CH_LOW_A : CH_UP_A) + v[7:0]);
      end
      3: send_char($urandom_range(1) ? CH_SQUOTE : CH_DQUOTE);
      4: begin
        send_char(CH_BSLASH);
        send_char(named[$urandom_range(8)]);
      end
      5: begin
        send_char(CH_BSLASH);
        v = $urandom_range(1, 255);
        send_char($urandom_range(1) ? lit[$urandom_range(4)] : v[7:0]);
      end
      6: begin
        send_char(CH_BSLASH);
        send_char(CH_LOW_X);
        n = $urandom_range(2);
        repeat (n) send_char(hex_char($urandom_range(15)));
      end
      7: begin
        send_char(CH_BSLASH);
        n = $urandom_range(1, 3);
        repeat (n) begin
          v = $urandom_range(7);
          send_char(CH_ZERO + v[7:0]);
        end
        // a following 8 or 9 must not be taken as an octal digit
        if ($urandom_range(3) == 0) send_char($urandom_range(1) ? CH_NINE : CH_NINE - 8'd1);
      end
      8: begin
        v = $urandom_range(128, 255);
        send_char(v[7:0]);
      end
      9: begin
        v = $urandom_range(1, 255);
        send_char(v[7:0]);
      end
      10: send_char(hex_char($urandom_range(15)));
      default: send_char(blank_char());
    endcase
  endtask

  task automatic send_string();
    int ntok;
    int npieces;
    int q;
    int v;
    if ($urandom_range(9) < 7) begin
      if ($urandom_range(2) == 0) send_char(blank_char());
      ntok = $urandom_range(1, 4);
      for (int i = 0; i < ntok; i++) begin
        q = $urandom_range(5);
        if (q == 0) send_char(CH_SQUOTE);
        else if (q == 1) send_char(CH_DQUOTE);
        npieces = $urandom_range(1, 5);
        repeat (npieces) send_piece();
        if (q == 0) send_char(CH_SQUOTE);
        else if (q == 1) send_char(CH_DQUOTE);
        if (i < ntok - 1 || $urandom_range(1))
          send_char($urandom_range(1) ? CH_SPACE : CH_TAB);
      end
      send_char(CH_NUL);
    end else begin
      // raw noise, zero bytes included
      npieces = $urandom_range(1, 16);
      repeat (npieces) begin
        v = $urandom_range(255);
        send_char(v[7:0]);
      end
      if ($urandom_range(1)) send_char(CH_NUL);
    end
    n_strings++;
  endtask

  task automatic directed_part();
    logic [7:0] seq [$];
    seq = '{CH_SPACE, CH_TAB, CH_LF,
            8'hFF, 8'h80,
            CH_DQUOTE, CH_SQUOTE, CH_DQUOTE,
            CH_BSLASH, CH_LOW_X, CH_ZERO + 8'd4, CH_ZERO + 8'd1,
            CH_BSLASH, CH_LOW_X, 8'h5A,
            CH_BSLASH, CH_ZERO + 8'd1, CH_ZERO, CH_ZERO + 8'd1,
            CH_BSLASH, CH_ZERO, CH_NINE - 8'd1,
            CH_SPACE, CH_BSLASH, CH_NUL, CH_NUL};
    foreach (seq[i]) send_char(seq[i]);
    n_strings += 2;
  endtask

  task automatic random_phase(input int src_pct, input int snk_pct);
    int target;
    drain_results();
    sender_idle_pct = src_pct;
    sink_idle_pct   = snk_pct;
    target = n_sent + ITEMS_PER_PHASE;
    while (n_sent < target) send_string();
  endtask

  initial begin
    books = new();
    books.reset_state();
    rst              = 1'b1;
    chars_if.valid   = 1'b0;
    chars_if.char_in = 8'd0;
    tokens_if.ready  = 1'b0;
    sender_idle_pct  = 19;
    sink_idle_pct    = 71;
    n_sent           = 0;
    n_strings        = 0;
    quiet_cycles     = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_part();
    random_phase(19, 71);
    random_phase(71, 19);
    random_phase(0, 0);

    chars_if.valid <= 1'b0;
    while (books.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d characters in %0d strings; checked %0d token bytes closing %0d tokens",
             n_sent, n_strings, books.bytes_checked, books.tokens_closed);
    $display("Pacing covered a slow sink, a slow source and back-to-back transfers");
    if (books.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/qts_pkg.sv
design/qts_char_if.sv
design/qts_result_if.sv
design/qts_decode.sv
design/quoted_token_splitter_core.sv
tb/testbench.sv
